@@ design/sssp_pkg.sv @@
// Package with the shared types and constants of the shortest path block.
package sssp_pkg;

  // Action codes carried in the input transaction.
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  localparam int MAX_VERTICES = 64;
  localparam int DIST_W = 24;
  localparam int COST_W = 16;
  localparam int VIDX_W = 6;
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  typedef logic [DIST_W-1:0] dist_t;

  // One stored edge as held in the edge RAM.
  typedef struct packed {
    logic [VIDX_W-1:0] end_a;
    logic [VIDX_W-1:0] end_b;
    logic [COST_W-1:0] cost;
  } edge_t;

endpackage

@@ design/sssp_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/single_source_shortest_path.sv @@
// Top level of the single-source shortest path block over an undirected edge table.
//
// Input channel in_*: in_tuser carries action; in_tdata carries end_a, end_b,
// weight and source. After a clear, or an add to a table that is not full, the
// block is ready again in the next cycle, so edge loads can follow back to back.
// An add to a full table returns one result transaction with table_full set.
// A run transaction passes an init state, then one round per reached vertex and
// a last empty round. A round scans the vertices through the distance RAM to
// pick the closest unsettled one, then streams the edge RAM one edge per cycle
// through the shared add/compare unit. The length of a search is set by the
// single read port of each RAM. Vertices 1 to vertex_count-1, with vertex_count
// clamped to 2 to 64, are then emitted, each through a read state and an emit
// state, the final one with out_tlast set. in_tready stays low from a run until
// its last result has been taken. A stalled receiver holds the result in the
// output register and the sequencer waits. After reset the edge table is empty
// and vertex_count is 64; RAM contents are not cleared. cfg_wr_en writes
// vertex_count from cfg_wr_data; the user must do so only while the block is
// idle, as the block itself does not enforce it.
module single_source_shortest_path #(
  parameter int MAX_EDGES    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, lowest bit up: end_a[5:0], end_b[11:6], weight[27:12],
  // source[33:28], zero fill[39:34]
  input  logic [39:0] in_tdata,
  // in_tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, lowest bit up: vertex[5:0], distance[29:6], zero fill[31:30]
  output logic [31:0] out_tdata,
  // out_tuser, lowest bit up: reachable[0], table_full[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int NVMAX = sssp_pkg::MAX_VERTICES;
  localparam int VW = sssp_pkg::VIDX_W;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int TW = $clog2(MAX_EDGES + 1);
  localparam int CW = $clog2(NVMAX + 1);
  localparam int DW = sssp_pkg::DIST_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_PICK    = 3'd2;
  localparam logic [2:0] S_EDGE    = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;
  localparam logic [2:0] S_FULL    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [6:0]    vcount_r;
  logic [TW-1:0] etotal_r;
  logic [VW-1:0] src_r;
  logic [CW-1:0] nv;

  logic [NVMAX-1:0] reach_r, settled_r, init_reach;

  logic [CW-1:0]   scan_r;
  logic            cmp_v_r;
  logic [VW-1:0]   cmp_idx_r;
  logic            found_r;
  logic [VW-1:0]   pick_r;
  sssp_pkg::dist_t pick_dist_r;
  logic [TW-1:0]   eidx_r;
  logic            ed_v_r;
  logic            rl_v_r;
  logic [VW-1:0]   rl_to_r;
  sssp_pkg::dist_t rl_cand_r;
  logic            byp_v_r;
  logic [VW-1:0]   byp_addr_r;
  sssp_pkg::dist_t byp_data_r;

  logic        ovalid_r;
  logic [31:0] odata_r;
  logic [1:0]  ouser_r;
  logic        olast_r;

  sssp_pkg::edge_t wr_edge, rd_edge;
  logic            in_fire, ram_we, out_free;

  logic            dist_we;
  logic [VW-1:0]   dist_wr_addr, dist_rd_addr;
  sssp_pkg::dist_t dist_wr_data, dist_rd;

  logic pick_done, cmp_better, edge_more, edge_done;

  // Clamp the vertex count to the legal range.
  always_comb begin
    if (vcount_r < 7'd2) begin
      nv = CW'(2);
    end else if (32'(vcount_r) > NVMAX) begin
      nv = CW'(NVMAX);
    end else begin
      nv = CW'(vcount_r);
    end
  end

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign wr_edge.end_a = in_tdata[5:0];
  assign wr_edge.end_b = in_tdata[11:6];
  assign wr_edge.cost  = in_tdata[27:12];
  assign ram_we = in_fire && (in_tuser == sssp_pkg::ACT_ADD) &&
                  (32'(etotal_r) < MAX_EDGES);

  // Edge table storage.
  sssp_ram #(.WIDTH($bits(sssp_pkg::edge_t)), .DEPTH(MAX_EDGES)) u_edges (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(etotal_r[EW-1:0]),
    .wr_data(wr_edge),
    .rd_addr(eidx_r[EW-1:0]),
    .rd_data(rd_edge)
  );

  // Distance storage; an entry's value is only used while its reached bit is set.
  sssp_ram #(.WIDTH(DW), .DEPTH(NVMAX)) u_dist (
    .clk    (clk),
    .wr_en  (dist_we),
    .wr_addr(dist_wr_addr),
    .wr_data(dist_wr_data),
    .rd_addr(dist_rd_addr),
    .rd_data(dist_rd)
  );

  // Shared relaxation unit. The first stage takes the edge read and forms the
  // saturated candidate, the second compares it with the stored distance.
  logic            rel_hit_a, rel_hit_b, rel_hit, rel_en;
  logic [VW-1:0]   rel_to;
  logic [DW:0]     rel_sum;
  sssp_pkg::dist_t rel_cand, cur_dist;
  logic            in_range;

  always_comb begin
    in_range  = (CW'(rd_edge.end_a) < nv) && (CW'(rd_edge.end_b) < nv);
    rel_hit_a = in_range && (rd_edge.end_a == pick_r);
    rel_hit_b = in_range && (rd_edge.end_b == pick_r);
    rel_hit   = rel_hit_a || rel_hit_b;
    rel_to    = rel_hit_a ? rd_edge.end_b : rd_edge.end_a;
    rel_sum   = {1'b0, pick_dist_r} + (DW+1)'(rd_edge.cost);
    rel_cand  = rel_sum[DW] ? sssp_pkg::DIST_INF : rel_sum[DW-1:0];
    // A write in the previous cycle has not reached the RAM read yet.
    cur_dist  = (byp_v_r && byp_addr_r == rl_to_r) ? byp_data_r : dist_rd;
    rel_en    = rl_v_r && (!reach_r[rl_to_r] || rl_cand_r < cur_dist);
  end

  // Scan and edge walk status.
  assign pick_done  = (scan_r == nv) && !cmp_v_r;
  assign cmp_better = cmp_v_r && reach_r[cmp_idx_r] && !settled_r[cmp_idx_r] &&
                      (!found_r || dist_rd < pick_dist_r);
  assign edge_more  = (eidx_r < etotal_r);
  assign edge_done  = !edge_more && !ed_v_r && !rl_v_r;

  // Distance RAM port selection.
  always_comb begin
    init_reach = '0;
    if (CW'(src_r) < nv) begin
      init_reach[src_r] = 1'b1;
    end
    dist_rd_addr = scan_r[VW-1:0];
    if (state_r == S_EDGE) begin
      dist_rd_addr = rel_to;
    end
    if (state_r == S_INIT) begin
      dist_we      = (CW'(src_r) < nv);
      dist_wr_addr = src_r;
      dist_wr_data = '0;
    end else begin
      dist_we      = rel_en;
      dist_wr_addr = rl_to_r;
      dist_wr_data = rl_cand_r;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == sssp_pkg::ACT_RUN) begin
            state_nxt = S_INIT;
          end else if (in_tuser == sssp_pkg::ACT_ADD && !ram_we) begin
            state_nxt = S_FULL;
          end
        end
      end
      S_INIT:  state_nxt = (CW'(src_r) < nv) ? S_PICK : S_EMIT_RD;
      S_PICK: begin
        if (pick_done) begin
          state_nxt = found_r ? S_EDGE : S_EMIT_RD;
        end
      end
      S_EDGE: begin
        if (edge_done) begin
          state_nxt = S_PICK;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = (scan_r == nv - CW'(1)) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_FULL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vcount_r  <= 7'd64;
      etotal_r  <= '0;
      ovalid_r  <= 1'b0;
      reach_r   <= '0;
      settled_r <= '0;
      cmp_v_r   <= 1'b0;
      ed_v_r    <= 1'b0;
      rl_v_r    <= 1'b0;
      byp_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      if (in_fire && in_tuser == sssp_pkg::ACT_CLEAR) begin
        etotal_r <= '0;
      end else if (ram_we) begin
        etotal_r <= etotal_r + TW'(1);
      end
      if (state_r == S_FULL || (state_r == S_EMIT && out_free)) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      cmp_v_r <= (state_r == S_PICK) && (scan_r != nv);
      ed_v_r  <= (state_r == S_EDGE) && edge_more;
      rl_v_r  <= (state_r == S_EDGE) && ed_v_r && rel_hit;
      byp_v_r <= rel_en;
      case (state_r)
        S_INIT: begin
          reach_r   <= init_reach;
          settled_r <= '0;
        end
        S_PICK: begin
          if (pick_done && found_r) begin
            settled_r[pick_r] <= 1'b1;
          end
        end
        S_EDGE: begin
          if (rel_en) begin
            reach_r[rl_to_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: scan counters, pick, relaxation pipe and the output register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_r <= in_tdata[28+VW-1:28];
    end
    case (state_r)
      S_INIT: begin
        scan_r  <= (CW'(src_r) < nv) ? '0 : CW'(1);
        found_r <= 1'b0;
      end
      S_PICK: begin
        if (scan_r != nv) begin
          scan_r <= scan_r + CW'(1);
        end else if (!cmp_v_r) begin
          scan_r <= found_r ? '0 : CW'(1);
        end
        cmp_idx_r <= scan_r[VW-1:0];
        if (pick_done) begin
          found_r <= 1'b0;
          eidx_r  <= '0;
        end else if (cmp_better) begin
          found_r     <= 1'b1;
          pick_r      <= cmp_idx_r;
          pick_dist_r <= dist_rd;
        end
      end
      S_EDGE: begin
        if (edge_more) begin
          eidx_r <= eidx_r + TW'(1);
        end
        rl_to_r    <= rel_to;
        rl_cand_r  <= rel_cand;
        byp_addr_r <= rl_to_r;
        byp_data_r <= rl_cand_r;
      end
      S_EMIT: begin
        if (out_free) begin
          odata_r <= {2'b00,
                      reach_r[scan_r[VW-1:0]] ? dist_rd : sssp_pkg::DIST_INF,
                      scan_r[VW-1:0]};
          ouser_r <= {1'b0, reach_r[scan_r[VW-1:0]]};
          olast_r <= (scan_r == nv - CW'(1));
          scan_r  <= scan_r + CW'(1);
        end
      end
      S_FULL: begin
        odata_r <= '0;
        ouser_r <= 2'b10;
        olast_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  // A held result must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // No input is taken while a run is in progress.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready)
    else $error("ready during run");

  // A full-table result carries no reachable flag and no last mark.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tlast && !out_tuser[0])
    else $error("bad full result");

endmodule
